FILE: sv/fbr_pkg.sv
// fbr_pkg: shared constants for the framed byte receiver
`default_nettype none

package fbr_pkg;

	// default payload limit of a frame
	localparam int MaxPayloadDefault = 16;

	// parser phase codes
	localparam logic [2:0] PhSof  = 3'd0;
	localparam logic [2:0] PhId   = 3'd1;
	localparam logic [2:0] PhLen  = 3'd2;
	localparam logic [2:0] PhData = 3'd3;
	localparam logic [2:0] PhChk  = 3'd4;

	// status codes of a result word
	localparam logic [1:0] StNone    = 2'd0;
	localparam logic [1:0] StAccept  = 2'd1;
	localparam logic [1:0] StBadSum  = 2'd2;
	localparam logic [1:0] StTooLong = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CfgStartByte = 3'd0;
	localparam logic [2:0] CfgIdFirst   = 3'd1;
	localparam logic [2:0] CfgIdSecond  = 3'd2;
	localparam logic [2:0] CfgIdThird   = 3'd3;
	localparam logic [2:0] CfgIdWord    = 3'd4;

	// configuration reset values
	localparam logic [7:0] StartByteReset = 8'hAA;
	localparam logic [7:0] IdFirstReset   = 8'd1;
	localparam logic [7:0] IdSecondReset  = 8'd2;
	localparam logic [7:0] IdThirdReset   = 8'd3;
	localparam logic [7:0] IdWordReset    = 8'd4;

endpackage

`default_nettype wire

FILE: sv/framed_byte_receiver.sv
// framed_byte_receiver: frame parser for start, id, length, payload and checksum bytes
//
//   channel  direction  handshake                 payload
//   in       input      in_valid / in_stall       rx_byte
//   out      output     out_valid / out_stall     flag_first, flag_second, flag_third,
//                                                 word_value, status
//   cfg      input      cfg_wr_en (no handshake)  cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; each byte yields one result word in the next cycle.
// The parse state updates at the edge that takes the byte, so the phase and
// running sum loop is the only path that sets the rate.
// A single output register holds the result; a new byte is taken whenever that
// register is empty or is being emptied in the same cycle.
// Reset (arst_n low) returns the parser to start-byte hunting, clears the flag and
// word registers and loads the default id and start byte values.
`default_nettype none

module framed_byte_receiver #(
	parameter int MAX_PAYLOAD = fbr_pkg::MaxPayloadDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       flag_first,
	output logic [7:0]       flag_second,
	output logic [7:0]       flag_third,
	output logic [15:0]      word_value,
	output logic [1:0]       status,
	// configuration port
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

	// configuration registers
	logic [7:0] start_byte_q, id_first_q, id_second_q, id_third_q, id_word_q;

	// parse state
	logic [2:0]  phase_q, phase_d;
	logic [7:0]  frame_id_q, frame_id_d;
	logic [7:0]  frame_len_q, frame_len_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  pay_first_q, pay_first_d;
	logic [7:0]  pay_second_q, pay_second_d;
	logic [7:0]  flag_first_q, flag_first_d;
	logic [7:0]  flag_second_q, flag_second_d;
	logic [7:0]  flag_third_q, flag_third_d;
	logic [15:0] word_q, word_d;
	logic [1:0]  status_d;

	// result register
	logic        res_valid_q;
	logic [7:0]  res_first_q, res_second_q, res_third_q;
	logic [15:0] res_word_q;
	logic [1:0]  res_status_q;

	logic       in_take;
	logic [7:0] sum_add;
	logic [7:0] count_inc;

	assign in_stall  = res_valid_q && out_stall;
	assign in_take   = in_valid && !in_stall;
	assign sum_add   = sum_q + rx_byte;
	assign count_inc = count_q + 8'd1;

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= fbr_pkg::StartByteReset;
			id_first_q   <= fbr_pkg::IdFirstReset;
			id_second_q  <= fbr_pkg::IdSecondReset;
			id_third_q   <= fbr_pkg::IdThirdReset;
			id_word_q    <= fbr_pkg::IdWordReset;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				fbr_pkg::CfgStartByte: start_byte_q <= cfg_data;
				fbr_pkg::CfgIdFirst:   id_first_q   <= cfg_data;
				fbr_pkg::CfgIdSecond:  id_second_q  <= cfg_data;
				fbr_pkg::CfgIdThird:   id_third_q   <= cfg_data;
				fbr_pkg::CfgIdWord:    id_word_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// next parse state for the byte on the input
	always_comb begin
		phase_d       = phase_q;
		frame_id_d    = frame_id_q;
		frame_len_d   = frame_len_q;
		count_d       = count_q;
		sum_d         = sum_q;
		pay_first_d   = pay_first_q;
		pay_second_d  = pay_second_q;
		flag_first_d  = flag_first_q;
		flag_second_d = flag_second_q;
		flag_third_d  = flag_third_q;
		word_d        = word_q;
		status_d      = fbr_pkg::StNone;
		case (phase_q)
			fbr_pkg::PhId: begin
				frame_id_d = rx_byte;
				sum_d      = rx_byte;
				phase_d    = fbr_pkg::PhLen;
			end
			fbr_pkg::PhLen: begin
				frame_len_d = rx_byte;
				count_d     = 8'd0;
				sum_d       = sum_add;
				if (rx_byte > MaxLen) begin
					status_d = fbr_pkg::StTooLong;
					phase_d  = fbr_pkg::PhSof;
				end else if (rx_byte == 8'd0) begin
					phase_d = fbr_pkg::PhChk;
				end else begin
					phase_d = fbr_pkg::PhData;
				end
			end
			fbr_pkg::PhData: begin
				if (count_q == 8'd0) begin
					pay_first_d = rx_byte;
				end else if (count_q == 8'd1) begin
					pay_second_d = rx_byte;
				end
				sum_d   = sum_add;
				count_d = count_inc;
				if (count_inc >= frame_len_q) begin
					phase_d = fbr_pkg::PhChk;
				end
			end
			fbr_pkg::PhChk: begin
				if (rx_byte == sum_q) begin
					status_d = fbr_pkg::StAccept;
					// length 1 frames load every flag whose id matches
					if (frame_len_q == 8'd1) begin
						if (frame_id_q == id_first_q)  flag_first_d  = pay_first_q;
						if (frame_id_q == id_second_q) flag_second_d = pay_first_q;
						if (frame_id_q == id_third_q)  flag_third_d  = pay_first_q;
					end
					// length 2 word frame, high byte first
					if (frame_len_q == 8'd2 && frame_id_q == id_word_q) begin
						word_d = {pay_first_q, pay_second_q};
					end
				end else begin
					status_d = fbr_pkg::StBadSum;
				end
				count_d = 8'd0;
				phase_d = fbr_pkg::PhSof;
			end
			default: begin
				if (rx_byte == start_byte_q) begin
					phase_d = fbr_pkg::PhId;
				end else begin
					phase_d = fbr_pkg::PhSof;
				end
			end
		endcase
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= fbr_pkg::PhSof;
			frame_id_q    <= 8'd0;
			frame_len_q   <= 8'd0;
			count_q       <= 8'd0;
			sum_q         <= 8'd0;
			flag_first_q  <= 8'd0;
			flag_second_q <= 8'd0;
			flag_third_q  <= 8'd0;
			word_q        <= 16'd0;
		end else if (in_take) begin
			phase_q       <= phase_d;
			frame_id_q    <= frame_id_d;
			frame_len_q   <= frame_len_d;
			count_q       <= count_d;
			sum_q         <= sum_d;
			flag_first_q  <= flag_first_d;
			flag_second_q <= flag_second_d;
			flag_third_q  <= flag_third_d;
			word_q        <= word_d;
		end
	end

	// payload bytes, written before any read
	always_ff @(posedge clk) begin
		if (in_take) begin
			pay_first_q  <= pay_first_d;
			pay_second_q <= pay_second_d;
		end
	end

	// result word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_take) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			res_first_q  <= flag_first_d;
			res_second_q <= flag_second_d;
			res_third_q  <= flag_third_d;
			res_word_q   <= word_d;
			res_status_q <= status_d;
		end
	end

	assign out_valid   = res_valid_q;
	assign flag_first  = res_first_q;
	assign flag_second = res_second_q;
	assign flag_third  = res_third_q;
	assign word_value  = res_word_q;
	assign status      = res_status_q;

endmodule

`default_nettype wire

FILE: tb/sv/fbr_result_board.sv
// fbr_result_board: frame parser prediction and result word comparison for the testbench
package fbr_tb_pkg;

	import fbr_pkg::*;

	// one result word as seen on the output channel
	typedef struct packed {
		logic [7:0]  flag_first;
		logic [7:0]  flag_second;
		logic [7:0]  flag_third;
		logic [15:0] word_value;
		logic [1:0]  status;
	} fbr_word_t;

	class frame_result_board;

		// register copies
		logic [7:0]  start_byte;
		logic [7:0]  id_first;
		logic [7:0]  id_second;
		logic [7:0]  id_third;
		logic [7:0]  id_word;

		// parser copy
		logic [2:0]  phase;
		logic [7:0]  frame_id;
		logic [7:0]  frame_len;
		logic [7:0]  byte_count;
		logic [7:0]  running_sum;
		logic [7:0]  payload_hi;
		logic [7:0]  payload_lo;
		logic [7:0]  flag_a;
		logic [7:0]  flag_b;
		logic [7:0]  flag_c;
		logic [15:0] word_reg;

		// words still to come, oldest first
		fbr_word_t   words_due[$];

		int unsigned mismatches;
		int unsigned words_matched;
		int unsigned frames_ok;
		int unsigned frames_bad_sum;
		int unsigned frames_too_long;

		function new();
			start_byte  = StartByteReset;
			id_first    = IdFirstReset;
			id_second   = IdSecondReset;
			id_third    = IdThirdReset;
			id_word     = IdWordReset;
			phase       = PhSof;
			frame_id    = 8'd0;
			frame_len   = 8'd0;
			byte_count  = 8'd0;
			running_sum = 8'd0;
			payload_hi  = 8'd0;
			payload_lo  = 8'd0;
			flag_a      = 8'd0;
			flag_b      = 8'd0;
			flag_c      = 8'd0;
			word_reg    = 16'd0;
		endfunction

		// register write; spare indexes are ignored by the block
		function void set_reg(logic [2:0] idx, logic [7:0] val);
			case (idx)
				CfgStartByte: start_byte = val;
				CfgIdFirst:   id_first   = val;
				CfgIdSecond:  id_second  = val;
				CfgIdThird:   id_third   = val;
				CfgIdWord:    id_word    = val;
				default: ;
			endcase
		endfunction

		// advance the parser by one received byte and queue the word it yields
		function void parse_byte(logic [7:0] b);
			fbr_word_t w;
			logic [1:0] st;
			st = StNone;
			case (phase)
				PhId: begin
					frame_id    = b;
					running_sum = b;
					phase       = PhLen;
				end
				PhLen: begin
					frame_len   = b;
					byte_count  = 8'd0;
					running_sum = running_sum + b;
					if (b > MaxPayloadDefault) begin
						st    = StTooLong;
						phase = PhSof;
					end else if (b == 8'd0) begin
						phase = PhChk;
					end else begin
						phase = PhData;
					end
				end
				PhData: begin
					if (byte_count == 8'd0)
						payload_hi = b;
					else if (byte_count == 8'd1)
						payload_lo = b;
					running_sum = running_sum + b;
					byte_count  = byte_count + 8'd1;
					if (byte_count >= frame_len)
						phase = PhChk;
				end
				PhChk: begin
					if (b == running_sum) begin
						st = StAccept;
						// each matching flag id loads its register on its own
						if (frame_len == 8'd1) begin
							if (frame_id == id_first)
								flag_a = payload_hi;
							if (frame_id == id_second)
								flag_b = payload_hi;
							if (frame_id == id_third)
								flag_c = payload_hi;
						end
						if (frame_len == 8'd2 && frame_id == id_word)
							word_reg = {payload_hi, payload_lo};
					end else begin
						st = StBadSum;
					end
					byte_count = 8'd0;
					phase      = PhSof;
				end
				// hunting, and unused phase codes
				default: phase = (b == start_byte) ? PhId : PhSof;
			endcase
			w.flag_first  = flag_a;
			w.flag_second = flag_b;
			w.flag_third  = flag_c;
			w.word_value  = word_reg;
			w.status      = st;
			words_due.push_back(w);
		endfunction

		function string show(fbr_word_t w);
			return $sformatf("f1=%02h f2=%02h f3=%02h word=%04h status=%0d",
				w.flag_first, w.flag_second, w.flag_third, w.word_value, w.status);
		endfunction

		// compare one accepted result word with the oldest one due
		function void match_result(fbr_word_t got);
			fbr_word_t want;
			if (words_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: %s", show(got));
				return;
			end
			want = words_due.pop_front();
			words_matched++;
			case (want.status)
				StAccept:  frames_ok++;
				StBadSum:  frames_bad_sum++;
				StTooLong: frames_too_long++;
				default: ;
			endcase
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at word %0d: expected %s, got %s",
						words_matched, show(want), show(got));
			end
		endfunction

		function int unsigned outstanding();
			return words_due.size();
		endfunction

	endclass

endpackage

FILE: tb/sv/tb_framed_byte_receiver.sv
// tb_framed_byte_receiver: random and directed frame traffic against the framed byte receiver
module tb_framed_byte_receiver;

	timeunit 1ns;
	timeprecision 1ps;

	import fbr_pkg::*;
	import fbr_tb_pkg::*;

	// spare register indexes that the block ignores
	localparam logic [2:0] CfgSpareLow  = 3'd5;
	localparam logic [2:0] CfgSpareHigh = 3'd7;
	localparam int unsigned IdleLimit   = 2000;
	localparam int unsigned HoldCycles  = 300;
	localparam int unsigned PhaseBytes  = 210;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte     = 8'd0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [7:0]  flag_first;
	logic [7:0]  flag_second;
	logic [7:0]  flag_third;
	logic [15:0] word_value;
	logic [1:0]  status;
	logic        cfg_wr_en   = 1'b0;
	logic [2:0]  cfg_index   = 3'd0;
	logic [7:0]  cfg_data    = 8'd0;

	frame_result_board board = new();

	bit          tx_quiet = 1'b0;
	bit          rx_quiet = 1'b0;
	bit          hold_rx  = 1'b0;
	int unsigned bytes_sent;
	int unsigned settings_used;

	framed_byte_receiver dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.flag_first (flag_first),
		.flag_second(flag_second),
		.flag_third (flag_third),
		.word_value (word_value),
		.status     (status),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// offer one byte after a random gap and wait until it is taken
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		bit ok;
		gap = tx_quiet ? 0 : $urandom_range(10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do begin
			@(negedge clk);
			ok = !in_stall;
			@(posedge clk);
		end while (!ok);
		board.parse_byte(b);
		bytes_sent++;
	endtask

	// start byte, id, length, payload and checksum; overlong frames stop after the length
	task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
			input logic [7:0] p0, input logic [7:0] p1, input bit good);
		logic [7:0] sum;
		logic [7:0] pb;
		send_byte(board.start_byte);
		send_byte(id);
		send_byte(len);
		sum = id + len;
		if (len > MaxPayloadDefault)
			return;
		for (int i = 0; i < int'(len); i++) begin
			pb = (i == 0) ? p0 : (i == 1) ? p1 : 8'($urandom);
			send_byte(pb);
			sum = sum + pb;
		end
		send_byte(good ? sum : sum ^ 8'($urandom_range(1, 255)));
	endtask

	// mostly well-formed frames with random content, some noise and bad sums
	task automatic random_frame();
		logic [7:0] id;
		logic [7:0] len;
		int unsigned pick;
		tx_quiet = ($urandom_range(3) == 0);
		if ($urandom_range(7) == 0)
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
		case ($urandom_range(5))
			0: id = board.id_first;
			1: id = board.id_second;
			2: id = board.id_third;
			3: id = board.id_word;
			default: id = 8'($urandom);
		endcase
		pick = $urandom_range(19);
		if (pick < 7)
			len = 8'd1;
		else if (pick < 12)
			len = 8'd2;
		else if (pick == 12)
			len = 8'd0;
		else if (pick < 18)
			len = 8'($urandom_range(3, MaxPayloadDefault));
		else if (pick == 18)
			len = 8'(MaxPayloadDefault);
		else
			len = 8'($urandom_range(MaxPayloadDefault + 1, 255));
		send_frame(id, len, 8'($urandom), 8'($urandom), $urandom_range(6) != 0);
	endtask

	// stop offering and wait for every result word still due
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.outstanding() > 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [7:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		board.set_reg(idx, val);
	endtask

	// write all registers plus one spare index, block idle
	task automatic load_config(input logic [7:0] sb, input logic [7:0] i1,
			input logic [7:0] i2, input logic [7:0] i3, input logic [7:0] iw);
		cfg_write(CfgStartByte, sb);
		cfg_write(CfgIdFirst, i1);
		cfg_write(CfgIdSecond, i2);
		cfg_write(CfgIdThird, i3);
		cfg_write(CfgIdWord, iw);
		cfg_write(3'($urandom_range(CfgSpareLow, CfgSpareHigh)), 8'($urandom));
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	task automatic random_phase();
		int unsigned stop_at;
		stop_at = bytes_sent + PhaseBytes;
		while (bytes_sent < stop_at)
			random_frame();
		wait_drained();
	endtask

	// receiver: random stall per word, quiet stretches, one long hold-off on request
	initial begin
		int unsigned n;
		bit got;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_rx) begin
				hold_rx = 1'b0;
				out_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
			end
			if ($urandom_range(49) == 0)
				rx_quiet = !rx_quiet;
			n = rx_quiet ? 0 : $urandom_range(10);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do begin
				@(negedge clk);
				got = out_valid;
				@(posedge clk);
			end while (!got);
		end
	end

	// result monitor, sampled mid-cycle ahead of the accepting edge
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.match_result('{flag_first, flag_second, flag_third, word_value, status});
	end

	// watchdog on cycles with no word moving on either channel
	initial begin
		int unsigned idle;
		idle = 0;
		while (idle < IdleLimit) begin
			@(negedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("timeout: no word moved for %0d cycles", IdleLimit);
		$display("Verification failed");
		$finish;
	end

	// stimulus
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames under reset register values
		tx_quiet = 1'b0;
		send_frame(IdFirstReset, 8'd1, 8'hFF, 8'h00, 1'b1);
		send_frame(IdWordReset, 8'd2, 8'hFF, 8'h00, 1'b1);
		// overlong length drops the frame
		send_frame(IdSecondReset, 8'hFF, 8'h00, 8'h00, 1'b1);
		// zero length with a wrong checksum
		send_frame(IdThirdReset, 8'd0, 8'h00, 8'h00, 1'b0);
		// start byte used as id, no resync
		send_frame(StartByteReset, 8'd0, 8'h00, 8'h00, 1'b1);
		// flag id with the word length
		send_frame(IdThirdReset, 8'd2, 8'h00, StartByteReset, 1'b1);
		wait_drained();

		// all zero, every id equal
		load_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		random_phase();

		// all ones, with a long receiver hold-off so the input backs up
		load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		hold_rx = 1'b1;
		random_phase();

		// one random id shared by all rules
		begin
			logic [7:0] shared;
			shared = 8'($urandom);
			load_config(8'($urandom), shared, shared, shared, shared);
		end
		random_phase();

		load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		random_phase();

		load_config(StartByteReset, IdFirstReset, IdSecondReset, IdThirdReset, IdWordReset);
		random_phase();

		load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		random_phase();

		repeat (10) @(posedge clk);
		$display("%0d bytes over %0d register settings, %0d result words compared",
			bytes_sent, settings_used + 1, board.words_matched);
		$display("frames: %0d accepted, %0d bad checksum, %0d overlong; %0d mismatches",
			board.frames_ok, board.frames_bad_sum, board.frames_too_long, board.mismatches);
		if (board.mismatches == 0 && board.outstanding() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/fbr_pkg.sv
sv/framed_byte_receiver.sv
tb/sv/fbr_result_board.sv
tb/sv/tb_framed_byte_receiver.sv
